@@ design/ssm_pkg.sv @@
package ssm_pkg;

  // sort direction of one line pass
  typedef enum logic {
    DIR_UP,
    DIR_DOWN
  } dir_t;

endpackage

@@ design/ssm_cmpx.sv @@
module ssm_cmpx #(
  parameter int W = 16
) (
  input  logic [W-1:0]    carry,
  input  logic [W-1:0]    data,
  input  ssm_pkg::dir_t   dir,
  output logic [W-1:0]    keep,
  output logic [W-1:0]    fwd
);
  import ssm_pkg::*;

  logic carry_gt;

  assign carry_gt = carry > data;

  // ascending bubbles the larger value forward, descending the smaller
  always_comb begin
    if ((dir == DIR_UP) == carry_gt) begin
      keep = data;
      fwd  = carry;
    end else begin
      keep = carry;
      fwd  = data;
    end
  end

endmodule

@@ design/shear_sort_mesh.sv @@
// channel | beat fields          | handshake
// --------+----------------------+---------------------
// input   | value                | in_valid / in_stall
// output  | sorted_value, last   | out_valid / out_stall
//
// load takes SIDE*SIDE beats, one per cycle, row-major
// sort runs clog2(SIDE)+1 phases, each a row half then a column half, SIDE-1 passes over each line in turn;
//   every line pass streams through the one grid memory port pair and one compare unit
// emit passes each beat through memory read, output register and beat offered, and waits out stalls
// in_stall is high from the last load beat until the last result beat is taken
// rst is synchronous; the grid memory is not cleared, every entry is loaded before use
module shear_sort_mesh #(
  parameter int SIDE       = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] sorted_value,
  output logic        last
);
  import ssm_pkg::*;

  localparam int CELLS  = SIDE * SIDE;
  localparam int AW     = $clog2(CELLS);
  localparam int LW     = $clog2(SIDE);
  localparam int SW     = $clog2(SIDE + 2);
  localparam int PHASES = $clog2(SIDE) + 1;
  localparam int PW     = $clog2(PHASES);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SORT,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_OUT
  } state_t;

  state_t state;

  logic [VALUE_BITS-1:0] grid [CELLS];
  logic [VALUE_BITS-1:0] rdata;

  logic [AW-1:0]         load_count;
  logic [PW-1:0]         phase_count;
  logic                  col_half;
  logic [LW-1:0]         line;
  logic [LW-1:0]         pass;
  logic [SW-1:0]         step;
  logic [VALUE_BITS-1:0] carry;

  logic [LW-1:0]         emit_row;
  logic [LW-1:0]         emit_col;
  logic [VALUE_BITS-1:0] out_word;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [AW-1:0]         raddr;

  logic [31:0]           in_ext;
  logic [31:0]           out_ext;
  logic [VALUE_BITS-1:0] cmp_keep;
  logic [VALUE_BITS-1:0] cmp_fwd;
  dir_t                  dir;
  logic [LW-1:0]         wpos;
  logic [LW-1:0]         snake_col;
  logic                  load_beat;
  logic                  out_beat;

  function automatic logic [AW-1:0] cell_addr(input logic col, input logic [LW-1:0] ln,
                                              input logic [LW-1:0] pos);
    logic [AW-1:0] major;
    logic [AW-1:0] minor;
    major = col ? AW'(pos) : AW'(ln);
    minor = col ? AW'(ln) : AW'(pos);
    return AW'(major * AW'(SIDE)) + minor;
  endfunction

  assign in_ext       = 32'(value);
  assign out_ext      = 32'(out_word);
  assign sorted_value = out_ext[15:0];

  assign in_stall  = (state != S_LOAD);
  assign load_beat = in_valid && !in_stall;
  assign out_beat  = out_valid && !out_stall;

  assign dir = (!col_half && line[0]) ? DIR_DOWN : DIR_UP;

  ssm_cmpx #(.W(VALUE_BITS)) u_cmpx (
    .carry (carry),
    .data  (rdata),
    .dir   (dir),
    .keep  (cmp_keep),
    .fwd   (cmp_fwd)
  );

  // write address trails the read address by two positions; the final step drops the carry at the line end
  assign wpos      = (step == SW'(SIDE + 1)) ? LW'(SIDE - 1) : LW'(step - SW'(2));
  assign snake_col = emit_row[0] ? LW'(SIDE - 1) - emit_col : emit_col;

  always_comb begin
    we    = 1'b0;
    waddr = load_count;
    wdata = in_ext[VALUE_BITS-1:0];
    raddr = cell_addr(1'b0, emit_row, snake_col);
    case (state)
      S_LOAD: begin
        we = load_beat;
      end
      S_SORT: begin
        raddr = cell_addr(col_half, line, LW'(step));
        waddr = cell_addr(col_half, line, wpos);
        if (step == SW'(SIDE + 1)) begin
          we    = 1'b1;
          wdata = carry;
        end else if (step >= SW'(2)) begin
          we    = 1'b1;
          wdata = cmp_keep;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      grid[waddr] <= wdata;
    end
    rdata <= grid[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      load_count  <= '0;
      phase_count <= '0;
      col_half    <= 1'b0;
      line        <= '0;
      pass        <= '0;
      step        <= '0;
      emit_row    <= '0;
      emit_col    <= '0;
      out_valid   <= 1'b0;
      last        <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (load_beat) begin
            if (load_count == AW'(CELLS - 1)) begin
              load_count  <= '0;
              phase_count <= '0;
              col_half    <= 1'b0;
              line        <= '0;
              pass        <= '0;
              step        <= '0;
              state       <= S_SORT;
            end else begin
              load_count <= load_count + AW'(1);
            end
          end
        end
        S_SORT: begin
          if (step == SW'(1)) begin
            carry <= rdata;
          end else if (step != SW'(0) && step != SW'(SIDE + 1)) begin
            carry <= cmp_fwd;
          end
          if (step == SW'(SIDE + 1)) begin
            step <= '0;
            if (pass == LW'(SIDE - 2)) begin
              pass <= '0;
              if (line == LW'(SIDE - 1)) begin
                line     <= '0;
                col_half <= !col_half;
                if (col_half) begin
                  if (phase_count == PW'(PHASES - 1)) begin
                    phase_count <= '0;
                    emit_row    <= '0;
                    emit_col    <= '0;
                    state       <= S_EMIT_RD;
                  end else begin
                    phase_count <= phase_count + PW'(1);
                  end
                end
              end else begin
                line <= line + LW'(1);
              end
            end else begin
              pass <= pass + LW'(1);
            end
          end else begin
            step <= step + SW'(1);
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_word  <= rdata;
          last      <= (emit_row == LW'(SIDE - 1)) && (emit_col == LW'(SIDE - 1));
          out_valid <= 1'b1;
          state     <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            last      <= 1'b0;
            if (last) begin
              state <= S_LOAD;
            end else begin
              if (emit_col == LW'(SIDE - 1)) begin
                emit_col <= '0;
                emit_row <= emit_row + LW'(1);
              end else begin
                emit_col <= emit_col + LW'(1);
              end
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_out_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_EMIT_OUT)
    else $error("result beat offered outside emit");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input open while results pending");

  a_load_to_sort: assert property (@(posedge clk) disable iff (rst)
    (load_beat && load_count == AW'(CELLS - 1)) |=> (state == S_SORT && step == SW'(0)))
    else $error("sort did not start after final load beat");

  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (out_beat && last) |=> (!in_stall && load_count == AW'(0)))
    else $error("input not reopened after last beat");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SORT |-> step <= SW'(SIDE + 1))
    else $error("pass step out of range");

endmodule
